// ===== src/slis_pkg.sv =====
package slis_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 32;
  localparam int OUT_LW   = 11;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;    // capture input beat, start search
    logic rd;      // issue table read at probe midpoint
    logic step;    // compare read data, narrow search window
    logic commit;  // write table, update length, load output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic search_done;
  } sts_t;

endpackage

// ===== src/slis_ctrl.sv =====
module slis_ctrl
  import slis_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PROBE  = 2'd1;
  localparam logic [1:0] ST_CMP    = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (sts.search_done) begin
          state_nxt = ST_COMMIT;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.step  = 1'b1;
        state_nxt = ST_PROBE;
      end
      ST_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output beat valid
  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A new beat always starts a search
  a_load_to_probe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_PROBE)
    else $error("load did not enter probe");

  // Commit never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("commit over pending result");

  // Reads only while the search is open
  a_rd_searching: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> !sts.search_done)
    else $error("read after search done");

endmodule

// ===== src/slis_dp.sv =====
module slis_dp
  import slis_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_last,
  output logic [OUT_LW-1:0]   out_ending_length,
  output logic [OUT_LW-1:0]   out_best_length,
  output logic                out_overflow,
  output logic                out_final_res
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam logic [LW-1:0] MAX_L = LW'(MAX_LEN);

  // Tail table: offset-binary tails so unsigned compare gives signed order
  logic [SAMPLE_W-1:0] mem [MAX_LEN];
  logic [SAMPLE_W-1:0] rdata_r;

  logic [SAMPLE_W-1:0] key_r;
  logic                last_r;
  logic [LW-1:0]       lo_r, lo_nxt;
  logic [LW-1:0]       hi_r, hi_nxt;
  logic [LW-1:0]       cur_r, cur_nxt;

  logic [LW:0]         span;
  logic [LW-1:0]       mid;
  logic [LW-1:0]       mid_m1;
  logic [LW-1:0]       below_p1;
  logic                ovf;
  logic [LW-1:0]       ending;
  logic [LW-1:0]       cur_upd;
  logic [LW+OUT_LW-1:0] end_ext, best_ext;

  logic [OUT_LW-1:0]   end_r, best_r;
  logic                ovf_r, fin_r;

  // Probe midpoint: lo + ceil((hi - lo) / 2)
  assign span   = {1'b0, hi_r} - {1'b0, lo_r} + (LW+1)'(1);
  assign mid    = lo_r + span[LW:1];
  assign mid_m1 = mid - LW'(1);

  assign sts.search_done = !(lo_r < hi_r);

  // Result of the finished search
  assign ovf      = (lo_r >= MAX_L);
  assign below_p1 = lo_r + LW'(1);
  assign ending   = ovf ? MAX_L : below_p1;
  assign cur_upd  = (!ovf && (below_p1 > cur_r)) ? below_p1 : cur_r;
  assign end_ext  = {{OUT_LW{1'b0}}, ending};
  assign best_ext = {{OUT_LW{1'b0}}, cur_upd};

  // Search window and length
  always_comb begin
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    cur_nxt = cur_r;
    if (cmd.load) begin
      lo_nxt = '0;
      hi_nxt = cur_r;
    end else if (cmd.step) begin
      if (rdata_r < key_r) begin
        lo_nxt = mid;
      end else begin
        hi_nxt = mid_m1;
      end
    end
    if (cmd.commit) begin
      cur_nxt = last_r ? '0 : cur_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r  <= '0;
      hi_r  <= '0;
      cur_r <= '0;
    end else begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      cur_r <= cur_nxt;
    end
  end

  // Input capture and output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= {~in_sample[SAMPLE_W-1], in_sample[SAMPLE_W-2:0]};
      last_r <= in_last;
    end
    if (cmd.commit) begin
      end_r  <= end_ext[OUT_LW-1:0];
      best_r <= best_ext[OUT_LW-1:0];
      ovf_r  <= ovf;
      fin_r  <= last_r;
    end
  end

  // Table port: one read, one write
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= mem[mid_m1[AW-1:0]];
    end
    if (cmd.commit && !ovf) begin
      mem[lo_r[AW-1:0]] <= key_r;
    end
  end

  assign out_ending_length = end_r;
  assign out_best_length   = best_r;
  assign out_overflow      = ovf_r;
  assign out_final_res     = fin_r;

  a_cur_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= MAX_L)
    else $error("length above table capacity");

  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    lo_r <= hi_r)
    else $error("search window inverted");

  a_step_open: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !sts.search_done)
    else $error("compare after search done");

endmodule

// ===== src/streaming_lis_length.sv =====
// Streaming LIS length: one result beat per input beat.
// Each input beat runs a binary search over the tail table in P probes
// (ceil(log2(len+1)), at most 11 at 1024); a new beat is taken only once the
// previous result is committed, and commit is held while an earlier result waits on
// out_ready; each probe is a registered table read followed by a compare.
// Reset (rst_n low, synchronous) clears the length and handshake state; the
// tail table holds no reset and needs no clear.
module streaming_lis_length
  import slis_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [OUT_LW-1:0]          out_ending_length,
  output logic [OUT_LW-1:0]          out_best_length,
  output logic                       out_overflow,
  output logic                       out_final_res
);

  cmd_t cmd;
  sts_t sts;

  slis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  slis_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_sample         (in_sample),
    .in_last           (in_last),
    .out_ending_length (out_ending_length),
    .out_best_length   (out_best_length),
    .out_overflow      (out_overflow),
    .out_final_res     (out_final_res)
  );

endmodule

// ===== tb/streaming_lis_length_tb.sv =====
`timescale 1ns / 1ps

module streaming_lis_length_tb;
  import slis_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 50;
  localparam int MAX_PRINTED = 100;
  localparam int SEQ_MAX = 40;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;

  // One expected result beat
  typedef struct packed {
    logic [OUT_LW-1:0] ending_length;
    logic [OUT_LW-1:0] best_length;
    logic              overflow;
    logic              final_res;
  } lis_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       in_last = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [OUT_LW-1:0]          out_ending_length;
  logic [OUT_LW-1:0]          out_best_length;
  logic                       out_overflow;
  logic                       out_final_res;

  // Predictor state: smallest tail per subsequence length, and the length in use
  logic signed [SAMPLE_W-1:0] lis_tails [TABLE_DEPTH];
  int unsigned                lis_len = 0;
  lis_result_t                lis_expect_q [$];
  lis_result_t                lis_want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  streaming_lis_length #(
    .MAX_LEN(TABLE_DEPTH)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ending_length(out_ending_length),
    .out_best_length  (out_best_length),
    .out_overflow     (out_overflow),
    .out_final_res    (out_final_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Patience-sort step: search the longest length whose tail is below the
  // sample, then lower (or append) the tail one length up
  function automatic lis_result_t lis_advance(input logic signed [SAMPLE_W-1:0] sample,
                                              input logic last);
    int lo;
    int hi;
    int mid;
    lis_result_t r;
    lo = 0;
    hi = (lis_len > TABLE_DEPTH) ? TABLE_DEPTH : lis_len;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (lis_tails[mid-1] < sample) lo = mid;
      else hi = mid - 1;
    end
    r.overflow = 1'b0;
    if (lo >= TABLE_DEPTH) begin
      // table full and sample above every tail: saturate
      r.ending_length = OUT_LW'(TABLE_DEPTH);
      r.overflow = 1'b1;
    end else begin
      r.ending_length = OUT_LW'(lo + 1);
      if (lo + 1 > lis_len) begin
        lis_tails[lo] = sample;
        lis_len = lo + 1;
      end else if (sample < lis_tails[lo]) begin
        lis_tails[lo] = sample;
      end
    end
    r.best_length = OUT_LW'(lis_len);
    r.final_res = last;
    if (last) lis_len = 0;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] to_sample(input longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("%0t MISMATCH: %s", $time, what);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Drive one input beat; valid stays high from the previous beat unless
  // an idle gap is taken
  task automatic send_beat(input logic signed [SAMPLE_W-1:0] sample, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= sample;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    lis_expect_q.push_back(lis_advance(sample, last));
  endtask

  // Hold off the sender until every expected result beat is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (lis_expect_q.size() != 0) @(posedge clk);
  endtask

  // Lone items, field extremes, duplicates, decreasing runs
  task automatic test_directed_edges();
    // single-item sequences: a lone last item
    send_beat(S_MIN, 1'b1);
    send_beat(S_MAX, 1'b1);
    // equal samples do not extend; extremes at both ends
    send_beat(32'sd0, 1'b0);
    send_beat(32'sd0, 1'b0);
    send_beat(-32'sd1, 1'b0);
    send_beat(32'sd1, 1'b0);
    send_beat(S_MIN, 1'b0);
    send_beat(32'sd2, 1'b0);
    send_beat(32'sd3, 1'b0);
    send_beat(S_MAX, 1'b0);
    send_beat(32'shaaaa_aaaa, 1'b0);
    send_beat(32'sh5555_5555, 1'b0);
    send_beat(-32'sd1, 1'b0);
    send_beat(32'sd100, 1'b0);
    send_beat(32'sd100, 1'b0);
    send_beat(S_MAX, 1'b1);
    // strictly decreasing: every ending length is 1
    send_beat(S_MAX, 1'b0);
    send_beat(32'sd1000, 1'b0);
    send_beat(32'sd0, 1'b0);
    send_beat(S_MIN, 1'b1);
  endtask

  // Short sequences: full-range noise, narrow range with many ties,
  // rising walks and falling walks
  task automatic test_random_sequences(input int n_items);
    int left;
    int seq_len;
    int style;
    int k;
    longint walk;
    logic signed [SAMPLE_W-1:0] s;
    left = n_items;
    while (left > 0) begin
      seq_len = $urandom_range(1, (left < SEQ_MAX) ? left : SEQ_MAX);
      style = $urandom_range(0, 3);
      walk = longint'($signed($urandom()));
      for (k = 0; k < seq_len; k++) begin
        case (style)
          0: s = $urandom();
          1: s = to_sample(longint'(int'($urandom_range(0, 16)) - 8));
          2: begin
            if ($urandom_range(0, 9) < 8) walk = walk + longint'($urandom_range(0, 5000));
            else walk = walk - longint'($urandom_range(0, 5000));
            s = to_sample(walk);
          end
          default: begin
            walk = walk - longint'($urandom_range(0, 100000));
            s = to_sample(walk);
          end
        endcase
        send_beat(s, k == seq_len - 1);
      end
      left -= seq_len;
    end
  endtask

  // One long rising sequence with noise: fills the whole table, then
  // saturates and raises overflow; idling changes every 256 beats
  task automatic test_table_overflow();
    int rises;
    int beats;
    longint climb;
    logic signed [SAMPLE_W-1:0] s;
    climb = -64'sd2147483648 + longint'($urandom_range(0, 1000));
    rises = 0;
    beats = 0;
    while (rises < TABLE_DEPTH + 16) begin
      if (beats % 256 == 0) begin
        case ((beats / 256) % 4)
          0: set_idling(0, 0);
          1: set_idling(82, 0);
          2: set_idling(0, 82);
          default: set_idling(22, 22);
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        s = to_sample(climb - longint'($urandom_range(0, 1 << 20)));
      end else begin
        climb = climb + longint'($urandom_range(1, 3000000));
        s = to_sample(climb);
        rises++;
      end
      send_beat(s, rises == TABLE_DEPTH + 16);
      beats++;
    end
  endtask

  // Receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result checker: each beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (lis_expect_q.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing expected", results_seen));
      end else begin
        lis_want = lis_expect_q.pop_front();
        if (out_ending_length !== lis_want.ending_length)
          report_mismatch($sformatf("beat %0d ending_length got %0d want %0d", results_seen,
                                    out_ending_length, lis_want.ending_length));
        if (out_best_length !== lis_want.best_length)
          report_mismatch($sformatf("beat %0d best_length got %0d want %0d", results_seen,
                                    out_best_length, lis_want.best_length));
        if (out_overflow !== lis_want.overflow)
          report_mismatch($sformatf("beat %0d overflow got %b want %b", results_seen,
                                    out_overflow, lis_want.overflow));
        if (out_final_res !== lis_want.final_res)
          report_mismatch($sformatf("beat %0d final_res got %b want %b", results_seen,
                                    out_final_res, lis_want.final_res));
      end
      results_seen++;
    end
  end

  // Watchdog: too long with no beat on either channel
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0, 0);
    test_directed_edges();
    drain_results();

    set_idling(82, 0);
    test_random_sequences(60);
    set_idling(0, 82);
    test_random_sequences(60);
    set_idling(22, 22);
    test_random_sequences(60);
    set_idling(0, 0);
    test_random_sequences(60);
    drain_results();

    test_table_overflow();
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (lis_expect_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", lis_expect_q.size()));
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
